/* sv/suk_pkg.sv */
// ----------------------------------------------------------------------------
// suk_pkg
// Shared types and constants of the sorted unique key set.
// ----------------------------------------------------------------------------
`default_nettype none

package suk_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_W       = 64;
	localparam int POS_W       = 11;
	localparam int PROBES_W    = 4;
	localparam int ENTRIES_W   = 11;
	localparam int STATUS_W    = 2;

	localparam logic CMD_PRELOAD = 1'b0;
	localparam logic CMD_INSERT  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_INSERTED    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_DUPLICATE   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_PRELOAD_DUP = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd3;

	typedef struct packed {
		logic                    cmd;
		logic signed [KEY_W-1:0] key;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [POS_W-1:0]     position;
		logic [PROBES_W-1:0]  probes;
		logic [ENTRIES_W-1:0] entries;
	} result_t;

	typedef struct packed {
		logic cmp;
		logic ins;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* sv/suk_cell.sv */
// ----------------------------------------------------------------------------
// suk_cell
// One slot of the sorted key row: compares against the broadcast key and
// shifts up from its lower neighbour on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module suk_cell #(
	parameter int IDX = 0,
	parameter int CW  = 11
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire suk_pkg::cell_ctl_t         ctl,
	input  wire [CW-1:0]                    cnt,
	input  wire logic signed [suk_pkg::KEY_W-1:0] key,
	input  wire logic signed [suk_pkg::KEY_W-1:0] prev_key,
	input  wire                             prev_lt,
	output logic signed [suk_pkg::KEY_W-1:0] stored_key,
	output logic                            lt,
	output logic                            eq,
	output logic                            first
);

	logic signed [suk_pkg::KEY_W-1:0] key_q;
	logic                             lt_q;
	logic                             eq_q;
	logic                             occ;

	assign occ        = cnt > CW'(IDX);
	assign first      = !lt_q && prev_lt;
	assign stored_key = key_q;
	assign lt         = lt_q;
	assign eq         = eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp) begin
			lt_q <= occ && (key_q < key);
			eq_q <= occ && (key_q == key);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (first) begin
				key_q <= key;
			end else if (!lt_q) begin
				key_q <= prev_key;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/suk_tree.sv */
// ----------------------------------------------------------------------------
// suk_tree
// Registered OR tree over the cell flags: match, insertion point and index.
// ----------------------------------------------------------------------------
`default_nettype none

module suk_tree #(
	parameter int DEPTH = suk_pkg::TABLE_DEPTH,
	parameter int CW    = 11
) (
	input  wire              clk,
	input  wire [DEPTH-1:0]  hit,
	input  wire [DEPTH-1:0]  first,
	output logic             found,
	output logic             any,
	output logic [CW-1:0]    pos
);

	localparam int L     = $clog2(DEPTH);
	localparam int NODES = 1 << L;

	typedef struct packed {
		logic          hit;
		logic          any;
		logic [CW-1:0] pos;
	} node_t;

	node_t leaf   [NODES];
	node_t node_q [NODES-1];

	for (genvar i = 0; i < NODES; i++) begin : g_leaf
		if (i < DEPTH) begin : g_used
			assign leaf[i] = '{hit: hit[i], any: first[i],
				pos: (first[i] ? CW'(i) : '0)};
		end else begin : g_pad
			assign leaf[i] = '0;
		end
	end

	for (genvar n = 0; n < NODES - 1; n++) begin : g_node
		node_t ca;
		node_t cb;
		if (2 * n + 1 >= NODES - 1) begin : g_from_leaf
			assign ca = leaf[2 * n + 1 - (NODES - 1)];
			assign cb = leaf[2 * n + 2 - (NODES - 1)];
		end else begin : g_from_node
			assign ca = node_q[2 * n + 1];
			assign cb = node_q[2 * n + 2];
		end
		always_ff @(posedge clk) begin
			node_q[n] <= node_t'(ca | cb);
		end
	end

	assign found = node_q[0].hit;
	assign any   = node_q[0].any;
	assign pos   = node_q[0].pos;

endmodule

`default_nettype wire

/* sv/suk_probe.sv */
// ----------------------------------------------------------------------------
// suk_probe
// Replays the exact-match binary search from the known position, one probe
// per cycle, and counts the probes.
// ----------------------------------------------------------------------------
`default_nettype none

module suk_probe #(
	parameter int CW  = 11,
	parameter int PCW = 11
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  wire            found,
	input  wire [CW-1:0]   pos,
	input  wire [CW-1:0]   cnt,
	output logic           busy,
	output logic [PCW-1:0] probes
);

	logic           busy_q;
	logic           found_q;
	logic [CW-1:0]  pos_q;
	logic [CW-1:0]  lo_q;
	logic [CW-1:0]  hi_q;
	logic [PCW-1:0] cnt_q;
	logic [CW-1:0]  mid;

	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign busy   = busy_q;
	assign probes = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (lo_q >= hi_q || (found_q && mid == pos_q)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			found_q <= found;
			pos_q   <= pos;
			lo_q    <= '0;
			hi_q    <= cnt;
			cnt_q   <= '0;
		end else if (busy_q && lo_q < hi_q) begin
			cnt_q <= cnt_q + PCW'(1);
			if (mid < pos_q) begin
				lo_q <= mid + CW'(1);
			end else begin
				hi_q <= mid;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/sorted_unique_key_set.sv */
// ----------------------------------------------------------------------------
// sorted_unique_key_set
// Sorted table of unique signed keys held in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// An item beat runs through the states CMP, TREE (the registered flag tree),
// START and PROBE (the search replay) to OUT, where the result is registered
// once the result slot is free.
// One item in flight: the next item beat is taken only after the result is
// registered.
// Reset clears the entry count and control; stored keys are left as they are.
`default_nettype none

module sorted_unique_key_set #(
	parameter int TABLE_DEPTH = suk_pkg::TABLE_DEPTH
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                item_valid,
	output logic               item_ready,
	input  wire suk_pkg::item_t item,
	output logic               result_valid,
	input  wire                result_ready,
	output suk_pkg::result_t   result
);

	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int PCW = (CW > suk_pkg::PROBES_W) ? CW : suk_pkg::PROBES_W;
	localparam int PXW = (CW > suk_pkg::POS_W) ? CW : suk_pkg::POS_W;
	localparam int EXW = (CW > suk_pkg::ENTRIES_W) ? CW : suk_pkg::ENTRIES_W;
	localparam int L   = $clog2(TABLE_DEPTH);
	localparam int TW  = $clog2(L + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CMP   = 3'd1;
	localparam logic [2:0] ST_TREE  = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_PROBE = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]                        state_q;
	logic [TW-1:0]                     tcnt_q;
	logic [CW-1:0]                     count_q;
	logic                              cmd_q;
	logic signed [suk_pkg::KEY_W-1:0]  key_q;
	logic                              found_q;
	logic [CW-1:0]                     pos_q;
	logic                              res_valid_q;
	suk_pkg::result_t                  res_q;

	suk_pkg::cell_ctl_t                ctl;
	logic signed [suk_pkg::KEY_W-1:0]  cell_key [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]            cell_lt;
	logic [TABLE_DEPTH-1:0]            cell_eq;
	logic [TABLE_DEPTH-1:0]            cell_first;

	logic                              t_found;
	logic                              t_any;
	logic [CW-1:0]                     t_pos;
	logic [CW-1:0]                     pos_sel;
	logic                              p_busy;
	logic [PCW-1:0]                    p_probes;

	logic                              full;
	logic                              do_out;
	logic                              do_ins;
	logic [suk_pkg::STATUS_W-1:0]      status;
	logic [CW-1:0]                     count_nxt;
	logic [PXW-1:0]                    pos_x;
	logic [EXW-1:0]                    cnt_x;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign full    = (count_q == CW'(TABLE_DEPTH));
	assign do_out  = (state_q == ST_OUT) && (!res_valid_q || result_ready);
	assign do_ins  = do_out && !found_q && !full;
	assign pos_sel = t_any ? t_pos : count_q;

	assign ctl.cmp = (state_q == ST_CMP);
	assign ctl.ins = do_ins;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		logic signed [suk_pkg::KEY_W-1:0] prev_key;
		logic                             prev_lt;
		if (g == 0) begin : g_head
			assign prev_key = key_q;
			assign prev_lt  = 1'b1;
		end else begin : g_body
			assign prev_key = cell_key[g-1];
			assign prev_lt  = cell_lt[g-1];
		end
		suk_cell #(
			.IDX (g),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.cnt        (count_q),
			.key        (key_q),
			.prev_key   (prev_key),
			.prev_lt    (prev_lt),
			.stored_key (cell_key[g]),
			.lt         (cell_lt[g]),
			.eq         (cell_eq[g]),
			.first      (cell_first[g])
		);
	end

	suk_tree #(
		.DEPTH (TABLE_DEPTH),
		.CW    (CW)
	) u_tree (
		.clk   (clk),
		.hit   (cell_eq),
		.first (cell_first),
		.found (t_found),
		.any   (t_any),
		.pos   (t_pos)
	);

	suk_probe #(
		.CW  (CW),
		.PCW (PCW)
	) u_probe (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_START),
		.found  (t_found),
		.pos    (pos_sel),
		.cnt    (count_q),
		.busy   (p_busy),
		.probes (p_probes)
	);

	always_comb begin
		if (found_q) begin
			status = (cmd_q == suk_pkg::CMD_INSERT) ? suk_pkg::STATUS_DUPLICATE
				: suk_pkg::STATUS_PRELOAD_DUP;
		end else if (full) begin
			status = suk_pkg::STATUS_FULL;
		end else begin
			status = suk_pkg::STATUS_INSERTED;
		end
	end

	assign count_nxt = do_ins ? count_q + CW'(1) : count_q;
	assign pos_x     = PXW'(pos_q);
	assign cnt_x     = EXW'(count_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tcnt_q      <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (do_out) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			count_q <= count_nxt;
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					tcnt_q  <= '0;
					state_q <= ST_TREE;
				end
				ST_TREE: begin
					tcnt_q <= tcnt_q + TW'(1);
					if (tcnt_q == TW'(L - 1)) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_PROBE;
				end
				ST_PROBE: begin
					if (!p_busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (do_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			cmd_q <= item.cmd;
			key_q <= item.key;
		end
		if (state_q == ST_START) begin
			found_q <= t_found;
			pos_q   <= pos_sel;
		end
		if (do_out) begin
			res_q.status   <= status;
			res_q.position <= pos_x[suk_pkg::POS_W-1:0];
			res_q.probes   <= p_probes[suk_pkg::PROBES_W-1:0];
			res_q.entries  <= cnt_x[suk_pkg::ENTRIES_W-1:0];
		end
	end

endmodule

`default_nettype wire
